// ===== rtl/cstrip_pkg.sv =====
// cstrip_pkg: shared types and character codes for the comment stripper
// scan mode encoding, result and step structs used by cstrip_step and the top level
// no dependencies
package cstrip_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_LINE       = 4'd2,
        MODE_BLOCK      = 4'd3,
        MODE_BLOCK_STAR = 4'd4,
        MODE_DQ         = 4'd5,
        MODE_DQ_ESC     = 4'd6,
        MODE_SQ         = 4'd7,
        MODE_SQ_ESC     = 4'd8
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
    } result_t;

    typedef struct packed {
        scan_mode_t mode_next;
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } step_t;

endpackage

// ===== rtl/cstrip_step.sv =====
// cstrip_step: next-state table of the comment stripper for one input byte
// gives the next scan mode and up to two results; depends on cstrip_pkg
module cstrip_step
    import cstrip_pkg::*;
(
    input  scan_mode_t mode,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output step_t      step
);

    scan_mode_t mode_n;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       v0;
    logic       e0;
    logic       e1;
    logic       do_normal;

    always_comb
    begin
        mode_n    = mode;
        cnt       = 2'd0;
        b0        = 8'h00;
        b1        = 8'h00;
        v0        = 1'b1;
        e0        = 1'b0;
        e1        = 1'b0;
        do_normal = 1'b0;

        case (mode)
            MODE_SLASH:
            begin
                if (in_byte == CH_SLASH)
                    mode_n = MODE_LINE;
                else if (in_byte == CH_STAR)
                    mode_n = MODE_BLOCK;
                else
                begin
                    // release the held slash, then treat the byte as plain text
                    b0        = CH_SLASH;
                    cnt       = 2'd1;
                    do_normal = 1'b1;
                end
            end
            MODE_LINE:
            begin
                if (in_byte == CH_NL)
                begin
                    b0     = in_byte;
                    cnt    = 2'd1;
                    mode_n = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (in_byte == CH_STAR)
                    mode_n = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (in_byte == CH_SLASH)
                    mode_n = MODE_NORMAL;
                else if (in_byte != CH_STAR)
                    mode_n = MODE_BLOCK;
            end
            MODE_DQ:
            begin
                b0  = in_byte;
                cnt = 2'd1;
                if (in_byte == CH_BSLASH)
                    mode_n = MODE_DQ_ESC;
                else if (in_byte == CH_DQUOTE)
                    mode_n = MODE_NORMAL;
            end
            MODE_DQ_ESC:
            begin
                b0     = in_byte;
                cnt    = 2'd1;
                mode_n = MODE_DQ;
            end
            MODE_SQ:
            begin
                b0  = in_byte;
                cnt = 2'd1;
                if (in_byte == CH_BSLASH)
                    mode_n = MODE_SQ_ESC;
                else if (in_byte == CH_SQUOTE)
                    mode_n = MODE_NORMAL;
            end
            MODE_SQ_ESC:
            begin
                b0     = in_byte;
                cnt    = 2'd1;
                mode_n = MODE_SQ;
            end
            default:
            begin
                do_normal = 1'b1;
            end
        endcase

        if (do_normal)
        begin
            if (in_byte == CH_SLASH)
                mode_n = MODE_SLASH;
            else
            begin
                if (cnt == 2'd0)
                    b0 = in_byte;
                else
                    b1 = in_byte;
                cnt = cnt + 2'd1;
                if (in_byte == CH_DQUOTE)
                    mode_n = MODE_DQ;
                else if (in_byte == CH_SQUOTE)
                    mode_n = MODE_SQ;
                else
                    mode_n = MODE_NORMAL;
            end
        end

        if (in_last)
        begin
            // a slash still held at the end goes out as a character
            if (mode_n == MODE_SLASH)
            begin
                if (cnt == 2'd0)
                    b0 = CH_SLASH;
                else
                    b1 = CH_SLASH;
                cnt = cnt + 2'd1;
            end
            mode_n = MODE_NORMAL;
            if (cnt == 2'd0)
            begin
                // bare end mark
                cnt = 2'd1;
                b0  = 8'h00;
                v0  = 1'b0;
                e0  = 1'b1;
            end
            else if (cnt == 2'd1)
                e0 = 1'b1;
            else
                e1 = 1'b1;
        end
    end

    always_comb
    begin
        step.mode_next        = mode_n;
        step.count            = cnt;
        step.res0.out_byte    = b0;
        step.res0.byte_valid  = v0;
        step.res0.end_of_text = e0;
        step.res1.out_byte    = b1;
        step.res1.byte_valid  = 1'b1;
        step.res1.end_of_text = e1;
    end

endmodule

// ===== rtl/comment_stripper.sv =====
// comment_stripper: top level, input register, scan mode register and result pair buffer
// depends on cstrip_pkg and cstrip_step
//
// Strips C-style comments from a byte stream. Each request carries one source byte in
// s_axis_tdata and the end-of-text flag in s_axis_tlast. Results carry the kept byte in
// m_axis_tdata, byte_valid in m_axis_tuser (0 only on a bare end mark) and end_of_text in
// m_axis_tlast. A byte passes from the input register through the next-state table into a
// two-entry result buffer. Both are registers, and a byte moves into the buffer only once
// the buffer can take its results. One byte is taken per cycle while each byte yields at most
// one result and the master side is ready; a byte that yields two results (a held slash
// released ahead of the byte that follows it) holds the input side until the buffer has room,
// since the result buffer drains one result per cycle while m_axis_tready is high. Bytes that
// yield nothing (inside comments) also go at one per cycle.
module comment_stripper
    import cstrip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast    // end_of_text
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    res0_reg;
    result_t    res0_next;
    result_t    res1_reg;
    result_t    res1_next;

    step_t      step;
    logic       pop;
    logic       load_ok;
    logic       process;
    logic       s_accept;

    cstrip_step u_step (
        .mode    (mode_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .step    (step)
    );

    assign pop      = m_axis_tvalid && m_axis_tready;
    // buffer can take a new pair once it is empty after this cycle
    assign load_ok  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign process  = in_valid_reg && load_ok;
    assign s_axis_tready = !in_valid_reg || load_ok;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = res0_reg.out_byte;
    assign m_axis_tuser  = res0_reg.byte_valid;
    assign m_axis_tlast  = res0_reg.end_of_text;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        mode_next = mode_reg;
        if (process)
            mode_next = step.mode_next;

        cnt_next  = cnt_reg;
        res0_next = res0_reg;
        res1_next = res1_reg;
        if (process)
        begin
            cnt_next  = step.count;
            res0_next = step.res0;
            res1_next = step.res1;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            res0_next = res1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_NORMAL;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

endmodule
